// ===== src/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and helpers of the base64 stream decoder
// Holds the group entry moved from front to back, queue status and the
// character-to-sextet mapping.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [7:0] LOWER_BIAS   = 8'h47;   // 'a' - 26
   localparam logic [7:0] DIGIT_BIAS   = 8'h04;   // 52 - '0'

   localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
   localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
   localparam logic [1:0] LAST_IDX_THREE = 2'd2;

   // One group of up to three results, first byte in the high bits.
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  last_idx;
      logic        byte_valid;
      logic        last;
   } grp_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   // Returns {ok, sextet}; ok is low outside the alphabet (pad included).
   function automatic logic [6:0] sextet_of(input logic [7:0] sym);
      logic [7:0] v;
      logic       ok;
      v  = 8'h00;
      ok = 1'b1;
      if (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) begin
         v = sym - CHAR_UPPER_A;
      end else if (sym >= CHAR_LOWER_A && sym <= CHAR_LOWER_Z) begin
         v = sym - LOWER_BIAS;
      end else if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
         v = sym + DIGIT_BIAS;
      end else if (sym == CHAR_PLUS) begin
         v = 8'd62;
      end else if (sym == CHAR_SLASH) begin
         v = 8'd63;
      end else begin
         ok = 1'b0;
      end
      return {ok, v[5:0]};
   endfunction

endpackage

// ===== src/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, one character per transfer
// Front end groups sextets, a four-entry queue buffers byte groups, and the
// back end sends decoded bytes one per transfer.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the req_ channel and returns
// decoded bytes on the rsp_ channel, one byte per transfer. Every fourth
// character of the alphabet releases three bytes; '=' or any other character
// halts decoding until the end-of-message item (req_kind = 1), which flushes
// a partial group (one or two bytes) or, with nothing to flush, sends one
// transfer with rsp_byte_valid low; the final transfer of a message carries
// rsp_last. A completed group passes through the queue, the back end's group
// register and its output register. Input is taken every cycle as long as the
// four-entry group queue has room; the back end sends one byte per cycle while
// rsp_stall is low, so a full-rate stream of 4 characters per 3 bytes flows
// without stall; req_stall rises only once a held rsp_stall fills the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   input  logic [7:0] req_symbol,
   output logic       req_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   input  logic       rsp_stall
);

   bsd_pkg::grp_type   push_data;
   bsd_pkg::grp_type   head;
   bsd_pkg::qstat_type qstat;
   logic               push;
   logic               pop;

   // Classify characters and build byte groups.
   bsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .req_symbol (req_symbol),
      .req_stall  (req_stall),
      .q_full     (qstat.full),
      .push       (push),
      .push_data  (push_data)
   );

   // Hold groups so either side can stall on its own.
   bsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   // Advance through each group one byte per transfer.
   bsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_valid        (!qstat.empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_stall      (rsp_stall)
   );

   // Never push into a full queue: a group would be lost.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("group pushed into full queue");

   // Queue occupancy stays within its depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

   // An empty end marker is always the final transfer of its message.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_last)
      else $error("transfer without byte is not marked last");

   // Pop only when the queue holds a group.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

endmodule

// ===== src/bsd_front.sv =====
// ----------------------------------------------------------------------------
// bsd_front: character intake and grouping
// Maps characters to sextets, tracks the held group and halting, and pushes
// a finished group of result bytes into the queue.
// ----------------------------------------------------------------------------
module bsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_kind,
   input  logic [7:0]       req_symbol,
   output logic             req_stall,
   input  logic             q_full,
   output logic             push,
   output bsd_pkg::grp_type push_data
);

   logic [17:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        halted_ff, halted_in;
   logic        accept;
   logic [6:0]  sx;
   logic [23:0] word;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign sx        = bsd_pkg::sextet_of(req_symbol);
   assign word      = {held_ff, sx[5:0]};

   always_comb begin
      held_in   = held_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (req_kind) begin
            push = 1'b1;
            push_data.last = 1'b1;
            case (count_ff)
               2'd2: begin
                  push_data.bytes      = {held_ff[11:4], 16'h0000};
                  push_data.last_idx   = bsd_pkg::LAST_IDX_ONE;
                  push_data.byte_valid = 1'b1;
               end
               2'd3: begin
                  push_data.bytes      = {held_ff[17:10], held_ff[9:2], 8'h00};
                  push_data.last_idx   = bsd_pkg::LAST_IDX_TWO;
                  push_data.byte_valid = 1'b1;
               end
               default: begin
                  push_data.last_idx   = bsd_pkg::LAST_IDX_ONE;
                  push_data.byte_valid = 1'b0;
               end
            endcase
            held_in   = '0;
            count_in  = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            if (!sx[6]) begin
               halted_in = 1'b1;
            end else if (count_ff == 2'd3) begin
               push                 = 1'b1;
               push_data.bytes      = word;
               push_data.last_idx   = bsd_pkg::LAST_IDX_THREE;
               push_data.byte_valid = 1'b1;
               held_in  = '0;
               count_in = '0;
            end else begin
               held_in  = {held_ff[11:0], sx[5:0]};
               count_in = count_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ===== src/bsd_queue.sv =====
// ----------------------------------------------------------------------------
// bsd_queue: group queue between front and back
// A small register FIFO of result groups with full and empty status.
// ----------------------------------------------------------------------------
module bsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsd_pkg::grp_type   push_data,
   input  logic               pop,
   output bsd_pkg::grp_type   head,
   output bsd_pkg::qstat_type stat
);

   bsd_pkg::grp_type                 entry_ff [bsd_pkg::QUEUE_DEPTH];
   logic [bsd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bsd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bsd_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign stat.full  = (count_ff == bsd_pkg::QCNT_W'(bsd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;
   assign head       = entry_ff[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + bsd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + bsd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + bsd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - bsd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/bsd_back.sv =====
// ----------------------------------------------------------------------------
// bsd_back: result sequencer
// Takes groups from the queue and sends their bytes one per transfer through
// a registered output.
// ----------------------------------------------------------------------------
module bsd_back (
   input  logic             clock,
   input  logic             reset,
   input  bsd_pkg::grp_type head,
   input  logic             q_valid,
   output logic             pop,
   output logic             rsp_valid,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   input  logic             rsp_stall
);

   bsd_pkg::grp_type cur_ff, cur_in;
   logic             busy_ff, busy_in;
   logic [1:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_bv_ff, out_bv_in;
   logic             out_last_ff, out_last_in;
   logic             load_out, done;
   logic [7:0]       sel_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = cur_ff.bytes[23:16];
         2'd1:    sel_byte = cur_ff.bytes[15:8];
         default: sel_byte = cur_ff.bytes[7:0];
      endcase
   end

   assign load_out = busy_ff && (!out_valid_ff || !rsp_stall);
   assign done     = load_out && (idx_ff == cur_ff.last_idx);
   assign pop      = q_valid && (!busy_ff || done);

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_bv_in    = out_bv_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         out_bv_in    = cur_ff.byte_valid;
         out_last_in  = cur_ff.last && (idx_ff == cur_ff.last_idx);
         idx_in       = idx_ff + 2'd1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         cur_in  = head;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_bv_ff   <= out_bv_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_byte  = out_byte_ff;
   assign rsp_byte_valid = out_bv_ff;
   assign rsp_last       = out_last_ff;

endmodule
